>>> hdl/ism_pkg.sv
package ism_pkg;

   localparam int MAX_SUBS        = 64;
   localparam int MAX_CONSTRAINTS = 256;
   localparam int NUM_ATTRS       = 16;

   localparam int SUB_W   = $clog2(MAX_SUBS);
   localparam int SCNT_W  = $clog2(MAX_SUBS + 1);
   localparam int CIDX_W  = $clog2(MAX_CONSTRAINTS);
   localparam int CCNT_W  = $clog2(MAX_CONSTRAINTS + 1);
   localparam int ATTR_W  = 4;
   localparam int VAL_W   = 16;
   localparam int ENTRY_W = ATTR_W + 2 * VAL_W + SUB_W;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_CLOSE = 2'd1,
      REQ_PAIR  = 2'd2,
      REQ_END   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_MATCH    = 2'd2,
      ST_NO_MATCH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_TAIL,
      S_WALK,
      S_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request item
      logic add;        // store constraint
      logic close;      // bump subscription count
      logic scan_start; // clear scan index
      logic scan_step;  // issue next read, evaluate previous
      logic scan_eval;  // evaluate last read only
      logic walk_start;
      logic walk_step;
      logic set_rsp;    // place single response
      logic rsp_match;  // response is a walk hit
      logic clear_map;
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;  // all stored entries issued
      logic scan_empty;
      logic walk_hit;   // current subscription unexcluded
      logic walk_last;  // no match beyond current index
      logic any_hit;
      logic add_ok;
      logic close_ok;
      logic pair_ok;
   } stat_type;

endpackage

>>> hdl/interval_subscription_matcher.sv
// channel | dir | tdata bits (low first)                      | tuser | tlast
// req     | in  | req_type[1:0] attr[5:2] low[21:6] high[37:22] | -     | -
// rsp     | out | sub_id[5:0] status[7:6]                      | -     | last
// Add and close pass through the output state and wait there until the response is
// taken. A publication pair reads the store one entry per cycle and gives no response.
// Publication end walks the subscription bits up to the last match, one per cycle
// while no match response waits for output.
// Reset is synchronous and empties the store; rsp_tready low holds the block.
module interval_subscription_matcher
   import ism_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // req_type, attribute, low_value, high_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // sub_id, status
   output logic        rsp_tlast
);

   ctrl_type          ctrl;
   stat_type          stat;
   logic              req_fire;
   logic [SUB_W-1:0]  id;
   logic [1:0]        st;

   assign req_fire = req_tvalid && req_tready;

   ism_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_code   (req_tdata[1:0]),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .req_ready  (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_last   (rsp_tlast),
      .ctrl       (ctrl)
   );

   ism_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .in_type    (req_tdata[1:0]),
      .in_attr    (req_tdata[5:2]),
      .in_low     (req_tdata[21:6]),
      .in_high    (req_tdata[37:22]),
      .rsp_id     (id),
      .rsp_status (st)
   );

   assign rsp_tdata = {st, id};

   property p_idle_ready;
      @(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready;
   endproperty
   assert property (p_idle_ready) else $error("ready while result pending");

   property p_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty
   assert property (p_hold) else $error("result dropped");

   property p_one_cmd;
      @(posedge clock) disable iff (reset) $onehot0({ctrl.add, ctrl.close, ctrl.scan_step});
   endproperty
   assert property (p_one_cmd) else $error("conflicting commands");

endmodule

>>> hdl/ism_ram.sv
module ism_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> hdl/ism_datapath.sv
module ism_datapath
   import ism_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   output stat_type          stat,
   input  logic [1:0]        in_type,
   input  logic [ATTR_W-1:0] in_attr,
   input  logic [VAL_W-1:0]  in_low,
   input  logic [VAL_W-1:0]  in_high,
   output logic [SUB_W-1:0]  rsp_id,
   output logic [1:0]        rsp_status
);

   logic [ATTR_W-1:0] attr_ff;
   logic [VAL_W-1:0]  low_ff, high_ff;
   logic [1:0]        type_ff;
   logic [SCNT_W-1:0] sub_count_ff;
   logic [CCNT_W-1:0] con_count_ff;
   logic [MAX_SUBS-1:0] excl_ff;
   logic [CCNT_W-1:0] scan_ff;
   logic [SUB_W-1:0]  walk_ff;
   logic              hit_seen_ff;
   logic [SUB_W-1:0]  rsp_id_ff;
   logic [1:0]        rsp_status_ff;
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] wr_data;

   logic [ATTR_W-1:0] e_attr;
   logic [VAL_W-1:0]  e_lo, e_hi;
   logic [SUB_W-1:0]  e_owner;
   logic              e_excl;
   logic [SCNT_W-1:0] walk_ext;
   logic [MAX_SUBS-1:0] live_subs;
   logic [MAX_SUBS-1:0] above_walk;

   assign wr_data = {attr_ff, low_ff, high_ff, sub_count_ff[SUB_W-1:0]};
   assign {e_attr, e_lo, e_hi, e_owner} = rd_data;
   // exact interval test: same attribute and low value outside the stored range
   assign e_excl = (e_attr == attr_ff) && ((e_lo > low_ff) || (e_hi < low_ff));
   assign walk_ext = SCNT_W'(walk_ff);
   // closed and not excluded subscriptions, and the indexes past the walk
   assign live_subs  = ~excl_ff & ~({MAX_SUBS{1'b1}} << sub_count_ff);
   assign above_walk = {MAX_SUBS{1'b1}} << (walk_ext + 1'b1);

   ism_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CONSTRAINTS)) u_store (
      .clock   (clock),
      .wr_en   (ctrl.add),
      .wr_addr (con_count_ff[CIDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (scan_ff[CIDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         type_ff <= in_type;
         attr_ff <= in_attr;
         low_ff  <= in_low;
         high_ff <= in_high;
      end
      if (ctrl.set_rsp) begin
         if (ctrl.rsp_match) begin
            rsp_id_ff     <= walk_ff;
            rsp_status_ff <= ST_MATCH;
         end else begin
            unique case (req_code_type'(type_ff))
               REQ_ADD: begin
                  rsp_id_ff     <= stat.add_ok ? sub_count_ff[SUB_W-1:0] : '0;
                  rsp_status_ff <= stat.add_ok ? ST_ACCEPTED : ST_FULL;
               end
               REQ_CLOSE: begin
                  rsp_id_ff     <= stat.close_ok ? sub_count_ff[SUB_W-1:0] : '0;
                  rsp_status_ff <= stat.close_ok ? ST_ACCEPTED : ST_FULL;
               end
               default: begin
                  rsp_id_ff     <= '0;
                  rsp_status_ff <= ST_NO_MATCH;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_count_ff <= '0;
         con_count_ff <= '0;
         excl_ff      <= '0;
         scan_ff      <= '0;
         walk_ff      <= '0;
         hit_seen_ff  <= 1'b0;
      end else begin
         if (ctrl.add)   con_count_ff <= con_count_ff + 1'b1;
         if (ctrl.close) sub_count_ff <= sub_count_ff + 1'b1;
         if (ctrl.scan_start) scan_ff <= '0;
         else if (ctrl.scan_step) scan_ff <= scan_ff + 1'b1;
         if ((ctrl.scan_step && scan_ff != '0) || ctrl.scan_eval) begin
            if (e_excl) excl_ff[e_owner] <= 1'b1;
         end
         if (ctrl.walk_start) begin
            walk_ff     <= '0;
            hit_seen_ff <= 1'b0;
         end else if (ctrl.walk_step) begin
            walk_ff <= walk_ff + 1'b1;
            if (stat.walk_hit) hit_seen_ff <= 1'b1;
         end
         if (ctrl.clear_map) excl_ff <= '0;
      end
   end

   always_comb begin
      stat.scan_done  = (scan_ff == con_count_ff);
      stat.scan_empty = (con_count_ff == '0);
      stat.walk_hit   = (walk_ext < sub_count_ff) && !excl_ff[walk_ff];
      // no match left beyond the current index
      stat.walk_last  = !(|(live_subs & above_walk));
      stat.any_hit    = hit_seen_ff;
      stat.add_ok     = (con_count_ff < CCNT_W'(MAX_CONSTRAINTS))
                        && (sub_count_ff < SCNT_W'(MAX_SUBS))
                        && ({1'b0, attr_ff} < (ATTR_W + 1)'(NUM_ATTRS));
      stat.close_ok   = (sub_count_ff < SCNT_W'(MAX_SUBS));
      stat.pair_ok    = ({1'b0, attr_ff} < (ATTR_W + 1)'(NUM_ATTRS));
   end

   assign rsp_id     = rsp_id_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> hdl/ism_control.sv
module ism_control
   import ism_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  logic [1:0] req_code,
   input  stat_type   stat,
   input  logic       rsp_tready,
   output logic       req_ready,
   output logic       rsp_valid,
   output logic       rsp_last,
   output ctrl_type   ctrl
);

   state_type    state_ff, state_in;
   req_code_type code_ff, code_in;
   logic         last_ff, last_in;
   logic         valid_ff, valid_in;
   logic         ret_ff, ret_in;   // return to walk after output

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= REQ_ADD;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
         ret_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      valid_in = valid_ff;
      last_in  = last_ff;
      ret_in   = ret_ff;
      ctrl     = '0;
      ctrl.load = req_fire;
      if (req_fire) code_in = req_code_type'(req_code);
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_code_type'(req_code))
                  REQ_PAIR: begin
                     ctrl.scan_start = 1'b1;
                     state_in = S_SCAN;
                  end
                  REQ_END: begin
                     ctrl.walk_start = 1'b1;
                     state_in = S_WALK;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_SCAN: begin
            if (!stat.pair_ok || stat.scan_empty) begin
               state_in = S_IDLE;
            end else if (stat.scan_done) begin
               ctrl.scan_eval = 1'b1;
               state_in = S_IDLE;
            end else begin
               ctrl.scan_step = 1'b1;
            end
         end
         S_SCAN_TAIL: state_in = S_IDLE;
         S_WALK: begin
            if (stat.walk_hit) begin
               ctrl.set_rsp   = 1'b1;
               ctrl.rsp_match = 1'b1;
               valid_in = 1'b1;
               last_in  = stat.walk_last;
               ret_in   = !stat.walk_last;
               ctrl.walk_step = 1'b1;
               if (stat.walk_last) ctrl.clear_map = 1'b1;
               state_in = S_OUT;
            end else if (stat.walk_last) begin
               ctrl.clear_map = 1'b1;
               if (stat.any_hit) begin
                  // the final hit already ended the walk
                  state_in = S_IDLE;
               end else begin
                  ctrl.set_rsp = 1'b1;
                  valid_in = 1'b1;
                  last_in  = 1'b1;
                  ret_in   = 1'b0;
                  state_in = S_OUT;
               end
            end else begin
               ctrl.walk_step = 1'b1;
            end
         end
         S_OUT: begin
            if (!valid_ff) begin
               ctrl.set_rsp = 1'b1;
               valid_in = 1'b1;
               last_in  = 1'b1;
               ret_in   = 1'b0;
               if (code_ff == REQ_ADD) ctrl.add = stat.add_ok;
               if (code_ff == REQ_CLOSE) ctrl.close = stat.close_ok;
            end else if (rsp_tready) begin
               valid_in = 1'b0;
               state_in = ret_ff ? S_WALK : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_last  = last_ff;

endmodule
